[rtl/i2cmbe_pkg.sv]
// Shared codes, phase constants and state type of the I2C master byte engine.
package i2cmbe_pkg;

    // Request codes carried in the input tuser field
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam int unsigned DATA_BITS = 8;

    // Line operation indexes that follow the data bits of a write
    localparam logic [4:0] WR_DATA_END = 5'(3 * DATA_BITS);
    localparam logic [4:0] WR_ACK_SCL  = 5'(3 * DATA_BITS + 1);
    localparam logic [4:0] WR_ACK_PULL = 5'(3 * DATA_BITS + 2);

    // Line operation indexes that follow the data bits of a read
    localparam logic [4:0] RD_DATA_END = 5'(2 * DATA_BITS);
    localparam logic [4:0] RD_ACK_SET  = 5'(2 * DATA_BITS + 1);
    localparam logic [4:0] RD_ACK_SCL  = 5'(2 * DATA_BITS + 2);
    localparam logic [4:0] RD_ACK_PULL = 5'(2 * DATA_BITS + 3);

    typedef struct packed {
        logic       scl_pull;
        logic       sda_pull;
        logic [2:0] cmd;
        logic [4:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic       ack_choice;
        logic       nack;
        logic [7:0] last_rx;
    } t_eng_state;

    typedef struct packed {
        logic done;
        logic rejected;
    } t_step_flags;

endpackage

[rtl/i2cmbe_step.sv]
// Next-state logic of the engine: one command latch or one line operation per item.
module i2cmbe_step
    import i2cmbe_pkg::*;
(
    input  t_eng_state  i_state,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_read,
    input  logic        i_sda_sample,
    output t_eng_state  o_state,
    output t_step_flags o_flags
);

    logic       busy;
    logic       fin;
    logic [4:0] p;
    logic [4:0] sub;

    assign busy = (i_state.cmd != REQ_TICK);
    assign p    = i_state.phase;

    // During the data bits of a write the bit count equals phase / 3, so the
    // position inside the three-operation bit slot is phase minus three counts.
    assign sub = p - {i_state.bit_cnt, 1'b0} - {1'b0, i_state.bit_cnt};

    always_comb begin
        o_state          = i_state;
        o_flags.done     = 1'b0;
        o_flags.rejected = 1'b0;
        fin              = 1'b0;

        if (i_req_type == REQ_TICK) begin
            if (busy) begin
                unique case (i_state.cmd)
                    REQ_START: begin
                        if (p == 5'd0) begin
                            o_state.sda_pull = 1'b1;
                        end else begin
                            o_state.scl_pull = 1'b1;
                            fin              = 1'b1;
                        end
                    end
                    REQ_STOP: begin
                        if (p == 5'd0) begin
                            o_state.scl_pull = 1'b0;
                        end else begin
                            o_state.sda_pull = 1'b0;
                            fin              = 1'b1;
                        end
                    end
                    REQ_WRITE: begin
                        if (p < WR_DATA_END) begin
                            if (sub == 5'd0) begin
                                o_state.sda_pull = ~i_state.shift[7];
                            end else if (sub == 5'd1) begin
                                o_state.scl_pull = 1'b0;
                            end else begin
                                o_state.scl_pull = 1'b1;
                                o_state.shift    = {i_state.shift[6:0], 1'b0};
                                o_state.bit_cnt  = i_state.bit_cnt + 4'd1;
                            end
                        end else if (p == WR_DATA_END) begin
                            o_state.sda_pull = 1'b0;
                        end else if (p == WR_ACK_SCL) begin
                            o_state.scl_pull = 1'b0;
                            o_state.nack     = i_sda_sample;
                        end else if (p == WR_ACK_PULL) begin
                            o_state.scl_pull = 1'b1;
                        end else begin
                            o_state.sda_pull = 1'b1;
                            fin              = 1'b1;
                        end
                    end
                    REQ_READ: begin
                        if (p == 5'd0) begin
                            o_state.sda_pull = 1'b0;
                        end else if (p <= RD_DATA_END) begin
                            if (p[0]) begin
                                o_state.scl_pull = 1'b0;
                                o_state.shift    = {i_state.shift[6:0], i_sda_sample};
                            end else begin
                                o_state.scl_pull = 1'b1;
                                o_state.bit_cnt  = i_state.bit_cnt + 4'd1;
                            end
                        end else if (p == RD_ACK_SET) begin
                            o_state.sda_pull = i_state.ack_choice;
                        end else if (p == RD_ACK_SCL) begin
                            o_state.scl_pull = 1'b0;
                        end else if (p == RD_ACK_PULL) begin
                            o_state.scl_pull = 1'b1;
                        end else begin
                            o_state.sda_pull = 1'b1;
                            o_state.last_rx  = i_state.shift;
                            fin              = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase

                if (fin) begin
                    o_state.cmd   = REQ_TICK;
                    o_state.phase = 5'd0;
                end else begin
                    o_state.phase = p + 5'd1;
                end
                o_flags.done = fin;
            end
        end else if (i_req_type <= REQ_READ) begin
            if (busy) begin
                o_flags.rejected = 1'b1;
            end else begin
                o_state.cmd     = i_req_type;
                o_state.phase   = 5'd0;
                o_state.bit_cnt = 4'd0;
                if (i_req_type == REQ_WRITE) begin
                    o_state.shift = i_tx_byte;
                end else if (i_req_type == REQ_READ) begin
                    o_state.shift      = 8'd0;
                    o_state.ack_choice = i_ack_read;
                end
            end
        end
    end

endmodule

[rtl/i2c_master_byte_engine_unit.sv]
// Top level of the I2C master byte engine with stream ports and output skid stage.
// The result of an item is registered into the output register when the item is accepted,
// or into the skid register while an earlier result still waits for the master side.
// Throughput: one item per cycle while the skid register is empty; the engine state updates once per item.
// A two-entry output (result register and skid register) keeps the input ready
// while one result waits, so only a second waiting result stalls the input.
// Reset: both lines released, engine idle, all status and received data cleared.
module i2c_master_byte_engine_unit
    import i2cmbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] ack_read, [9] sda_sample
    input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_drive_low, [1] sda_drive_low, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] nack, [13] rejected
    output logic [15:0] m_axis_tdata
);

    t_eng_state  r_state;
    t_eng_state  n_state;
    t_step_flags step_flags;
    logic        in_accept;
    logic [15:0] result;

    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        r_skid_valid;
    logic [15:0] r_skid_data;

    i2cmbe_step u_step (
        .i_state      (r_state),
        .i_req_type   (s_axis_tuser),
        .i_tx_byte    (s_axis_tdata[7:0]),
        .i_ack_read   (s_axis_tdata[8]),
        .i_sda_sample (s_axis_tdata[9]),
        .o_state      (n_state),
        .o_flags      (step_flags)
    );

    assign s_axis_tready = ~r_skid_valid;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign result = {2'b00,
                     step_flags.rejected,
                     n_state.nack,
                     n_state.last_rx,
                     step_flags.done,
                     (n_state.cmd != REQ_TICK),
                     n_state.sda_pull,
                     n_state.scl_pull};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_data  <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
